// File: rtl/lrf_pkg.sv
// Shared types and constants of the rectangle fill byte stream.
`timescale 1ns / 1ps

package lrf_pkg;

    // Display link command bytes.
    localparam logic [7:0] CMD_COLUMN_WINDOW = 8'h2A;
    localparam logic [7:0] CMD_ROW_WINDOW    = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE  = 8'h2C;

    // Header byte positions; the pixel phase follows the last header byte.
    localparam logic [3:0] HDR_COL_CMD     = 4'd0;
    localparam logic [3:0] HDR_COL_FIRST_H = 4'd1;
    localparam logic [3:0] HDR_COL_FIRST_L = 4'd2;
    localparam logic [3:0] HDR_COL_LAST_H  = 4'd3;
    localparam logic [3:0] HDR_COL_LAST_L  = 4'd4;
    localparam logic [3:0] HDR_ROW_CMD     = 4'd5;
    localparam logic [3:0] HDR_ROW_FIRST_H = 4'd6;
    localparam logic [3:0] HDR_ROW_FIRST_L = 4'd7;
    localparam logic [3:0] HDR_ROW_LAST_H  = 4'd8;
    localparam logic [3:0] HDR_ROW_LAST_L  = 4'd9;
    localparam logic [3:0] HDR_MEM_CMD     = 4'd10;
    localparam logic [3:0] PIXEL_PHASE     = 4'd11;

    // Colour component order within one pixel.
    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    // Item kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PULL  = 1'b1;

    // Configuration register indexes.
    localparam int         CFG_IDX_W          = 2;
    localparam logic [1:0] CFG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_HEIGHT = 2'd1;

    localparam logic [10:0] DISPLAY_WIDTH_RESET  = 11'd480;
    localparam logic [10:0] DISPLAY_HEIGHT_RESET = 11'd320;

    // Default queue depths.
    localparam int CMD_DEPTH_DEFAULT = 2;
    localparam int RES_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [10:0]          data;
    } t_cfg_wr;

    // Classified word passed from the front to the back.
    typedef struct packed {
        logic        kind;
        logic        geom_ok;
        logic [10:0] col_first;
        logic [10:0] col_last;
        logic [10:0] row_first;
        logic [10:0] row_last;
        logic [10:0] width;
        logic [10:0] height;
        logic [15:0] color;
    } t_cmd;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       is_data;
        logic       release_select;
        logic       last_byte;
        logic       rejected;
        logic       busy_res;
    } t_res;

endpackage

// File: rtl/lcd_rect_fill_byte_stream.sv
// Top level of the rectangle fill byte stream for a display link.
`timescale 1ns / 1ps

// Channel   | Handshake                          | Payload
// ----------+------------------------------------+---------------------------------------
// input     | push / full (accept: push & !full) | i_kind, i_x_start, i_y_start,
//           |                                    | i_rect_width, i_rect_height, i_fill_color
// result    | empty / pop (accept: pop & !empty) | o_byte_valid, o_out_byte, o_is_data,
//           |                                    | o_release_select, o_last_byte,
//           |                                    | o_rejected, o_busy_res
// config    | i_cfg_valid / o_cfg_ready          | i_cfg_index, i_cfg_data
//
// Every word in gives exactly one result word. The front checks and clips a word
// combinationally, so it lands in the command queue at the accepting edge; the back
// sequencer then writes its result into the result queue, from which it is popped, and a
// full result queue holds the word in the command queue until there is room.
// The sequencer takes one word per cycle while the result queue has room and a word waits.
// Reset is synchronous and active low; it restores the panel size of 480 by 320 and
// leaves the block idle with both queues empty. A stalled result side fills the
// result queue, then the command queue, and then raises full.

module lcd_rect_fill_byte_stream
    import lrf_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT,
    parameter int RES_DEPTH = RES_DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input word channel.
    input  logic                 push,
    output logic                 full,
    input  logic                 i_kind,
    input  logic [15:0]          i_x_start,
    input  logic [15:0]          i_y_start,
    input  logic [15:0]          i_rect_width,
    input  logic [15:0]          i_rect_height,
    input  logic [15:0]          i_fill_color,
    // Result word channel.
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_byte_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_is_data,
    output logic                 o_release_select,
    output logic                 o_last_byte,
    output logic                 o_rejected,
    output logic                 o_busy_res,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [10:0]          i_cfg_data
);

    t_cfg_wr cfg_wr;
    t_cmd    front_cmd;
    t_cmd    back_cmd;
    t_res    back_res;
    t_res    out_res;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_full;
    logic    res_push;

    // The panel size registers take a write in any cycle.
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // The front checks and clips each start word as it is pushed.
    lrf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg_wr),
        .i_kind        (i_kind),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_fill_color  (i_fill_color),
        .o_cmd         (front_cmd)
    );

    // Classified words wait here until the sequencer can take them.
    lrf_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    // The sequencer owns the rectangle state and emits one result per word.
    lrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // Results queue up here so that the sequencer keeps going while the consumer stalls.
    lrf_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_byte_valid     = out_res.byte_valid;
    assign o_out_byte       = out_res.out_byte;
    assign o_is_data        = out_res.is_data;
    assign o_release_select = out_res.release_select;
    assign o_last_byte      = out_res.last_byte;
    assign o_rejected       = out_res.rejected;
    assign o_busy_res       = out_res.busy_res;

endmodule

// File: rtl/lrf_fifo.sv
// Small register queue used between the front, the back and the result port.
`timescale 1ns / 1ps

module lrf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/lrf_front.sv
// Front end: panel size registers, rectangle checks and clipping of start words.
`timescale 1ns / 1ps

module lrf_front
    import lrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        i_kind,
    input  logic [15:0] i_x_start,
    input  logic [15:0] i_y_start,
    input  logic [15:0] i_rect_width,
    input  logic [15:0] i_rect_height,
    input  logic [15:0] i_fill_color,
    output t_cmd        o_cmd
);

    logic [10:0] r_disp_w;
    logic [10:0] r_disp_h;
    logic [16:0] x_end;
    logic [16:0] y_end;
    logic [10:0] w_clip;
    logic [10:0] h_clip;
    logic        x_ok;
    logic        y_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= DISPLAY_WIDTH_RESET;
            r_disp_h <= DISPLAY_HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DISPLAY_WIDTH:  r_disp_w <= i_cfg.data;
                CFG_DISPLAY_HEIGHT: r_disp_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A start must begin on the panel and have nonzero size.
    assign x_ok  = (i_x_start < {5'd0, r_disp_w}) && (i_rect_width != '0);
    assign y_ok  = (i_y_start < {5'd0, r_disp_h}) && (i_rect_height != '0);
    assign x_end = {1'b0, i_x_start} + {1'b0, i_rect_width};
    assign y_end = {1'b0, i_y_start} + {1'b0, i_rect_height};

    // When the start is on the panel, the clipped size fits in 11 bits.
    always_comb begin
        if (x_end > {6'd0, r_disp_w}) begin
            w_clip = r_disp_w - i_x_start[10:0];
        end else begin
            w_clip = i_rect_width[10:0];
        end
        if (y_end > {6'd0, r_disp_h}) begin
            h_clip = r_disp_h - i_y_start[10:0];
        end else begin
            h_clip = i_rect_height[10:0];
        end
    end

    always_comb begin
        o_cmd.kind      = i_kind;
        o_cmd.geom_ok   = x_ok && y_ok;
        o_cmd.col_first = i_x_start[10:0];
        o_cmd.col_last  = i_x_start[10:0] + w_clip - 11'd1;
        o_cmd.row_first = i_y_start[10:0];
        o_cmd.row_last  = i_y_start[10:0] + h_clip - 11'd1;
        o_cmd.width     = w_clip;
        o_cmd.height    = h_clip;
        o_cmd.color     = i_fill_color;
    end

endmodule

// File: rtl/lrf_back.sv
// Back end: header and pixel byte sequencer that turns each word into one result.
`timescale 1ns / 1ps

module lrf_back
    import lrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_empty,
    output logic o_cmd_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    logic        r_active, n_active;
    logic [3:0]  r_hdr_idx, n_hdr_idx;
    logic [1:0]  r_comp, n_comp;
    logic [10:0] r_col_cnt, n_col_cnt;
    logic [10:0] r_row_cnt, n_row_cnt;
    logic [10:0] r_col_first, n_col_first;
    logic [10:0] r_col_last, n_col_last;
    logic [10:0] r_row_first, n_row_first;
    logic [10:0] r_row_last, n_row_last;
    logic [10:0] r_width, n_width;
    logic [15:0] r_color, n_color;
    logic        step;
    logic [7:0]  hdr_byte;
    logic        hdr_is_data;
    logic [7:0]  pix_byte;

    assign step       = !i_cmd_empty && !i_res_full;
    assign o_cmd_pop  = step;
    assign o_res_push = step;

    always_comb begin
        hdr_is_data = 1'b1;
        unique case (r_hdr_idx)
            HDR_COL_CMD: begin
                hdr_byte    = CMD_COLUMN_WINDOW;
                hdr_is_data = 1'b0;
            end
            HDR_COL_FIRST_H: hdr_byte = {5'd0, r_col_first[10:8]};
            HDR_COL_FIRST_L: hdr_byte = r_col_first[7:0];
            HDR_COL_LAST_H:  hdr_byte = {5'd0, r_col_last[10:8]};
            HDR_COL_LAST_L:  hdr_byte = r_col_last[7:0];
            HDR_ROW_CMD: begin
                hdr_byte    = CMD_ROW_WINDOW;
                hdr_is_data = 1'b0;
            end
            HDR_ROW_FIRST_H: hdr_byte = {5'd0, r_row_first[10:8]};
            HDR_ROW_FIRST_L: hdr_byte = r_row_first[7:0];
            HDR_ROW_LAST_H:  hdr_byte = {5'd0, r_row_last[10:8]};
            HDR_ROW_LAST_L:  hdr_byte = r_row_last[7:0];
            default: begin
                hdr_byte    = CMD_MEMORY_WRITE;
                hdr_is_data = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_comp)
            COMP_RED:   pix_byte = {r_color[15:11], 3'd0};
            COMP_GREEN: pix_byte = {r_color[10:5], 2'd0};
            default:    pix_byte = {r_color[4:0], 3'd0};
        endcase
    end

    always_comb begin
        n_active    = r_active;
        n_hdr_idx   = r_hdr_idx;
        n_comp      = r_comp;
        n_col_cnt   = r_col_cnt;
        n_row_cnt   = r_row_cnt;
        n_col_first = r_col_first;
        n_col_last  = r_col_last;
        n_row_first = r_row_first;
        n_row_last  = r_row_last;
        n_width     = r_width;
        n_color     = r_color;
        o_res       = '0;
        if (step) begin
            if (i_cmd.kind == KIND_START) begin
                if (r_active || !i_cmd.geom_ok) begin
                    o_res.rejected = 1'b1;
                end else begin
                    n_active    = 1'b1;
                    n_hdr_idx   = HDR_COL_CMD;
                    n_comp      = COMP_RED;
                    n_col_first = i_cmd.col_first;
                    n_col_last  = i_cmd.col_last;
                    n_row_first = i_cmd.row_first;
                    n_row_last  = i_cmd.row_last;
                    n_col_cnt   = i_cmd.width;
                    n_row_cnt   = i_cmd.height;
                    n_width     = i_cmd.width;
                    n_color     = i_cmd.color;
                end
            end else if (r_active) begin
                o_res.byte_valid = 1'b1;
                if (r_hdr_idx < PIXEL_PHASE) begin
                    o_res.out_byte       = hdr_byte;
                    o_res.is_data        = hdr_is_data;
                    o_res.release_select = 1'b1;
                    n_hdr_idx            = r_hdr_idx + 4'd1;
                end else begin
                    o_res.out_byte = pix_byte;
                    o_res.is_data  = 1'b1;
                    if (r_comp != COMP_BLUE) begin
                        n_comp = r_comp + 2'd1;
                    end else begin
                        n_comp = COMP_RED;
                        if (r_col_cnt > 11'd1) begin
                            n_col_cnt = r_col_cnt - 11'd1;
                        end else if (r_row_cnt > 11'd1) begin
                            n_row_cnt = r_row_cnt - 11'd1;
                            n_col_cnt = r_width;
                        end else begin
                            n_col_cnt            = '0;
                            n_row_cnt            = '0;
                            o_res.last_byte      = 1'b1;
                            o_res.release_select = 1'b1;
                            n_active             = 1'b0;
                            n_hdr_idx            = HDR_COL_CMD;
                        end
                    end
                end
            end
            o_res.busy_res = n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_hdr_idx <= HDR_COL_CMD;
            r_comp    <= COMP_RED;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else begin
            r_active  <= n_active;
            r_hdr_idx <= n_hdr_idx;
            r_comp    <= n_comp;
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_first <= n_col_first;
        r_col_last  <= n_col_last;
        r_row_first <= n_row_first;
        r_row_last  <= n_row_last;
        r_width     <= n_width;
        r_color     <= n_color;
    end

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.last_byte) |=> !r_active)
        else $error("rectangle still active after its last byte");

    a_last_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.last_byte) |->
            (o_res.release_select && o_res.is_data && !o_res.busy_res))
        else $error("last byte without release and data flags");

    a_reject_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.rejected) |-> !o_res.byte_valid)
        else $error("rejected start produced a byte");

    a_pixel_counts_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_hdr_idx == PIXEL_PHASE) |->
            (r_col_cnt != '0 && r_row_cnt != '0 && r_comp != 2'd3))
        else $error("pixel phase with exhausted counters");

endmodule
